// ----- rtl/per_pixel_running_median_unit_macros.svh -----
// ----------------------------------------------------------------------------
// per_pixel_running_median_unit_macros
// assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef PER_PIXEL_RUNNING_MEDIAN_UNIT_MACROS_SVH
`define PER_PIXEL_RUNNING_MEDIAN_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PPM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppm check failed");
`define PPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppm check failed");
`else
`define PPM_ASSERT_SAME(label, ante, cons)
`define PPM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/ppm_pkg.sv -----
// ----------------------------------------------------------------------------
// ppm_pkg
// shared widths and register indexes of the running median unit
// ----------------------------------------------------------------------------
package ppm_pkg;
  localparam int PIX_W     = 8;
  localparam int CNT_W     = 32;
  localparam int FPB_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_ENABLE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BUCKET = 1'b1;

  localparam logic [FPB_W-1:0] FPB_RESET = 16'd64;
endpackage

// ----- rtl/ppm_ram.sv -----
// ----------------------------------------------------------------------------
// ppm_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module ppm_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic                                 re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);
  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/ppm_queue.sv -----
// ----------------------------------------------------------------------------
// ppm_queue
// two entry queue between the classifying front and the update engine
// ----------------------------------------------------------------------------
module ppm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);
  logic [W-1:0] slot_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rptr_r];
endmodule

// ----- rtl/ppm_front.sv -----
// ----------------------------------------------------------------------------
// ppm_front
// accepts samples, tracks position, frame count and bucket rotation
// ----------------------------------------------------------------------------
module ppm_front #(
  parameter int PIXELS      = 1024,
  parameter int LEVEL_SHIFT = 4,
  parameter int BUCKETS     = 4,
  parameter int PW          = 10,
  parameter int BW          = 2,
  parameter int LW          = 4,
  parameter int JW          = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ppm_pkg::PIX_W-1:0]      in_tdata,
  input  logic                           in_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppm_pkg::FPB_W-1:0]      cfg_data,
  input  logic                           start_ok,
  output logic                           push,
  output logic [JW-1:0]                  job
);
  import ppm_pkg::*;

  localparam int SPW = FPB_W + BW + 1;

  logic                decay_en_r;
  logic [FPB_W-1:0]    fpb_r;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]    frame_r, frame_nxt;
  logic [BW-1:0]       bucket_r, bucket_nxt;
  logic                pend_r, pend_nxt;
  logic                busy_r, busy_nxt;
  logic [4:0]          mcnt_r, mcnt_nxt;
  logic [FPB_W-1:0]    rem_r, rem_nxt;
  logic [FPB_W:0]      trial;
  logic [FPB_W:0]      rnew;
  logic [SPW-1:0]      span;
  logic                at_end;
  logic [LW-1:0]       col;

  assign in_tready = !busy_r && start_ok;
  assign cfg_ready = !busy_r;
  assign push      = in_tvalid && in_tready;
  assign at_end    = (pos_r == PW'(PIXELS - 1));
  assign col       = LW'(in_tdata >> LEVEL_SHIFT);
  assign job       = {in_tlast, frame_r[CNT_W-1:1], bucket_r, pend_r, pos_r, col};
  assign span      = SPW'(fpb_r) * SPW'(BUCKETS);
  assign trial     = {rem_r, frame_r[~mcnt_r]};
  assign rnew      = (trial >= {1'b0, fpb_r}) ? trial - {1'b0, fpb_r} : trial;

  always_comb begin
    pos_nxt    = pos_r;
    frame_nxt  = frame_r;
    bucket_nxt = bucket_r;
    pend_nxt   = pend_r;
    busy_nxt   = busy_r;
    mcnt_nxt   = mcnt_r;
    rem_nxt    = rem_r;
    if (push) begin
      if (in_tlast || at_end) begin
        pend_nxt = 1'b0;
      end
      if (in_tlast) begin
        pos_nxt   = '0;
        frame_nxt = frame_r + 1'b1;
        if (decay_en_r && (fpb_r != '0)) begin
          busy_nxt = 1'b1;
          mcnt_nxt = '0;
          rem_nxt  = '0;
        end
      end else begin
        pos_nxt = at_end ? '0 : pos_r + 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt  = rnew[FPB_W-1:0];
      mcnt_nxt = mcnt_r + 1'b1;
      if (mcnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        if (rnew == '0) begin
          if (frame_r >= CNT_W'(span)) begin
            frame_nxt = frame_r - CNT_W'(fpb_r);
          end
          bucket_nxt = (bucket_r == BW'(BUCKETS - 1)) ? '0 : bucket_r + 1'b1;
          pend_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_en_r <= 1'b1;
      fpb_r      <= FPB_RESET;
      pos_r      <= '0;
      frame_r    <= '0;
      bucket_r   <= '0;
      pend_r     <= 1'b0;
      busy_r     <= 1'b0;
      mcnt_r     <= '0;
      rem_r      <= '0;
    end else begin
      pos_r    <= pos_nxt;
      frame_r  <= frame_nxt;
      bucket_r <= bucket_nxt;
      pend_r   <= pend_nxt;
      busy_r   <= busy_nxt;
      mcnt_r   <= mcnt_nxt;
      rem_r    <= rem_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DECAY_ENABLE:      decay_en_r <= cfg_data[0];
          REG_FRAMES_PER_BUCKET: fpb_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- rtl/ppm_back.sv -----
// ----------------------------------------------------------------------------
// ppm_back
// per pixel histogram update engine with decay and median stepping
// ----------------------------------------------------------------------------
module ppm_back #(
  parameter int PIXELS      = 1024,
  parameter int LEVEL_SHIFT = 4,
  parameter int BUCKETS     = 4,
  parameter int PW          = 10,
  parameter int BW          = 2,
  parameter int LW          = 4,
  parameter int JW          = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_valid,
  input  logic [JW-1:0]             job,
  output logic                      job_pop,
  output logic                      clearing,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ppm_pkg::PIX_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import ppm_pkg::*;

  localparam int LEVELS = 256 >> LEVEL_SHIFT;
  localparam int RW     = LEVELS * CNT_W;
  localparam int XW     = CNT_W + LW;
  localparam int CW     = PW + BW;
  localparam int BD     = BUCKETS << PW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_SUB  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_ADJ  = 3'd6;

  logic [2:0]                   st_r, st_nxt;
  logic [CW-1:0]                clr_r, clr_nxt;
  logic [LW-1:0]                lix_r, lix_nxt;
  logic [LW-1:0]                col_r, col_nxt;
  logic [PW-1:0]                p_r, p_nxt;
  logic                         dec_r, dec_nxt;
  logic [BW-1:0]                fresh_r, fresh_nxt;
  logic [CNT_W-2:0]             half_r, half_nxt;
  logic                         last_r, last_nxt;
  logic [LEVELS-1:0][CNT_W-1:0] lvl_r, lvl_nxt;
  logic [LEVELS-1:0][CNT_W-1:0] snap_r, snap_nxt;
  logic [LEVELS-1:0][CNT_W-1:0] bkt_r, bkt_nxt;
  logic [LEVELS-1:0][CNT_W-1:0] bdone;
  logic [CNT_W-1:0]             below_r, below_nxt;
  logic [LW-1:0]                med_r, med_nxt;
  logic                         ov_r, ov_nxt;
  logic [PIX_W-1:0]             od_r, od_nxt;
  logic                         ol_r, ol_nxt;
  logic [CNT_W-1:0]             below_fin;
  logic [LW-1:0]                med_fin;
  logic [CNT_W-1:0]             upsum;
  logic [BW-1:0]                done_b;

  logic [LW-1:0]                j_col;
  logic [PW-1:0]                j_p;
  logic                         j_dec;
  logic [BW-1:0]                j_bkt;
  logic [CNT_W-2:0]             j_half;
  logic                         j_last;

  logic          lvl_we, snap_we, bkt_we, pix_we, rd_en;
  logic [PW-1:0] mw_addr;
  logic [CW-1:0] bw_addr;
  logic [RW-1:0] lvl_wd, snap_wd, bkt_wd, lvl_rd, snap_rd, bkt_rd;
  logic [XW-1:0] pix_wd, pix_rd;
  logic          clr_row_ok;

  assign {j_last, j_half, j_bkt, j_dec, j_p, j_col} = job;

  assign clearing   = (st_r == S_CLR);
  assign job_pop    = (st_r == S_IDLE) && job_valid && !ov_r;
  assign rd_en      = job_pop;
  assign done_b     = (fresh_r == '0) ? BW'(BUCKETS - 1) : fresh_r - 1'b1;
  assign clr_row_ok = ({1'b0, clr_r[PW-1:0]} < (PW + 1)'(PIXELS));
  assign upsum      = below_r + lvl_r[med_r];

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      bdone[i] = lvl_r[i] - snap_r[i];
    end
  end

  always_comb begin
    below_fin = below_r;
    med_fin   = med_r;
    if (below_r > {1'b0, half_r}) begin
      if (med_r != '0) begin
        med_fin   = med_r - 1'b1;
        below_fin = below_r - lvl_r[med_r - 1'b1];
      end
    end else if (upsum < {1'b0, half_r}) begin
      if (med_r != LW'(LEVELS - 1)) begin
        med_fin   = med_r + 1'b1;
        below_fin = upsum;
      end
    end
  end

  always_comb begin
    mw_addr = clearing ? clr_r[PW-1:0] : p_r;
    bw_addr = clearing ? clr_r : {done_b, p_r};
    lvl_we  = (clearing && clr_row_ok) || (st_r == S_ADJ);
    snap_we = lvl_we;
    pix_we  = lvl_we;
    bkt_we  = clearing || (st_r == S_DEC);
    lvl_wd  = clearing ? '0 : RW'(lvl_r);
    snap_wd = clearing ? '0 : RW'(snap_r);
    bkt_wd  = clearing ? '0 : RW'(bdone);
    pix_wd  = clearing ? '0 : {below_fin, med_fin};
  end

  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    lix_nxt   = lix_r;
    col_nxt   = col_r;
    p_nxt     = p_r;
    dec_nxt   = dec_r;
    fresh_nxt = fresh_r;
    half_nxt  = half_r;
    last_nxt  = last_r;
    lvl_nxt   = lvl_r;
    snap_nxt  = snap_r;
    bkt_nxt   = bkt_r;
    below_nxt = below_r;
    med_nxt   = med_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    unique case (st_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(BD - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_pop) begin
          col_nxt   = j_col;
          p_nxt     = j_p;
          dec_nxt   = j_dec;
          fresh_nxt = j_bkt;
          half_nxt  = j_half;
          last_nxt  = j_last;
          st_nxt    = S_RD;
        end
      end
      S_RD: begin
        lvl_nxt   = lvl_rd;
        snap_nxt  = snap_rd;
        bkt_nxt   = bkt_rd;
        {below_nxt, med_nxt} = pix_rd;
        st_nxt    = dec_r ? S_DEC : S_UPD;
      end
      S_DEC: begin
        for (int i = 0; i < LEVELS; i++) begin
          lvl_nxt[i]  = lvl_r[i] - bkt_r[i];
          snap_nxt[i] = lvl_r[i] - bkt_r[i];
        end
        lix_nxt = '0;
        st_nxt  = S_SUB;
      end
      S_SUB: begin
        if (lix_r < med_r) begin
          below_nxt = below_r - bkt_r[lix_r];
          lix_nxt   = lix_r + 1'b1;
        end else begin
          st_nxt = S_UPD;
        end
      end
      S_UPD: begin
        lvl_nxt[col_r] = lvl_r[col_r] + 1'b1;
        below_nxt      = below_r + CNT_W'(col_r < med_r);
        st_nxt         = S_ADJ;
      end
      S_ADJ: begin
        ov_nxt = 1'b1;
        od_nxt = PIX_W'(med_fin) << LEVEL_SHIFT;
        ol_nxt = last_r;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
    lix_r   <= lix_nxt;
    col_r   <= col_nxt;
    p_r     <= p_nxt;
    dec_r   <= dec_nxt;
    fresh_r <= fresh_nxt;
    half_r  <= half_nxt;
    last_r  <= last_nxt;
    lvl_r   <= lvl_nxt;
    snap_r  <= snap_nxt;
    bkt_r   <= bkt_nxt;
    below_r <= below_nxt;
    med_r   <= med_nxt;
    od_r    <= od_nxt;
    ol_r    <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  ppm_ram #(.W(RW), .D(PIXELS)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(mw_addr), .wdata(lvl_wd),
    .re(rd_en), .raddr(j_p), .rdata(lvl_rd)
  );

  ppm_ram #(.W(RW), .D(PIXELS)) u_snap (
    .clk(clk), .we(snap_we), .waddr(mw_addr), .wdata(snap_wd),
    .re(rd_en), .raddr(j_p), .rdata(snap_rd)
  );

  ppm_ram #(.W(RW), .D(BD)) u_bkt (
    .clk(clk), .we(bkt_we), .waddr(bw_addr), .wdata(bkt_wd),
    .re(rd_en), .raddr({j_bkt, j_p}), .rdata(bkt_rd)
  );

  ppm_ram #(.W(XW), .D(PIXELS)) u_pix (
    .clk(clk), .we(pix_we), .waddr(mw_addr), .wdata(pix_wd),
    .re(rd_en), .raddr(j_p), .rdata(pix_rd)
  );
endmodule

// ----- rtl/per_pixel_running_median_unit.sv -----
// ----------------------------------------------------------------------------
// per_pixel_running_median_unit
// Running median per pixel from quantized level histograms. After reset the
// unit clears its memories, all BUCKETS * 2^ceil(log2(PIXELS)) bucket memory
// rows (4096 at the defaults), and takes no sample meanwhile. For each sample
// the update engine reads the pixel's histograms, increments the histogram,
// steps the median and writes back; it takes the next sample only once the
// previous result has left the output register. A sample that carries a
// pending bucket subtraction first subtracts the stored bucket histogram and
// then walks the levels below its median to correct the count below it.
// With decay enabled and a nonzero bucket size, the last sample of a frame
// holds the input while the bit-serial remainder unit checks for a bucket
// rotation.
// ----------------------------------------------------------------------------
module per_pixel_running_median_unit #(
  parameter int PIXELS      = 1024,
  parameter int LEVEL_SHIFT = 4,
  parameter int BUCKETS     = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ppm_pkg::PIX_W-1:0]      in_tdata,   // pixel_value
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ppm_pkg::PIX_W-1:0]      out_tdata,  // median_value
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppm_pkg::FPB_W-1:0]      cfg_data
);
  import ppm_pkg::*;

  `include "per_pixel_running_median_unit_macros.svh"

  localparam int PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int BW = $clog2(BUCKETS);
  localparam int LW = PIX_W - LEVEL_SHIFT;
  localparam int JW = LW + PW + 1 + BW + (CNT_W - 1) + 1;

  logic          q_push, q_push_ready, q_pop, q_pop_valid;
  logic [JW-1:0] q_in, q_out;
  logic          clearing;

  ppm_front #(
    .PIXELS(PIXELS), .LEVEL_SHIFT(LEVEL_SHIFT), .BUCKETS(BUCKETS),
    .PW(PW), .BW(BW), .LW(LW), .JW(JW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start_ok(q_push_ready && !clearing),
    .push(q_push), .job(q_in)
  );

  ppm_queue #(.W(JW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(q_in), .push_ready(q_push_ready),
    .pop(q_pop), .pop_valid(q_pop_valid), .pop_data(q_out)
  );

  ppm_back #(
    .PIXELS(PIXELS), .LEVEL_SHIFT(LEVEL_SHIFT), .BUCKETS(BUCKETS),
    .PW(PW), .BW(BW), .LW(LW), .JW(JW)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(q_pop_valid), .job(q_out), .job_pop(q_pop),
    .clearing(clearing),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // no sample enters while memories are being cleared
  `PPM_ASSERT_SAME(a_no_take_in_clear, clearing, !in_tready)
  // frame end with rotation check enabled starts the remainder unit
  `PPM_ASSERT_NEXT(a_frame_end_busy, in_tvalid && in_tready && in_tlast && u_front.decay_en_r && (u_front.fpb_r != '0), !cfg_ready && !in_tready)
  // engine only pulls work when the queue has some
  `PPM_ASSERT_SAME(a_pop_has_work, q_pop, q_pop_valid && !out_tvalid)
endmodule
